// File: rtl/nsd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the NMEA sentence decoder.
// Depends on nothing; every other file of the decoder but nsd_if uses it.
package nsd_pkg;

    typedef logic [3:0] t_kind;
    typedef logic [3:0] t_act;

    localparam t_kind KIND_OTHER = 4'd0;
    localparam t_kind KIND_RMC   = 4'd1;
    localparam t_kind KIND_GGA   = 4'd2;
    localparam t_kind KIND_GNS   = 4'd3;
    localparam t_kind KIND_ZDA   = 4'd4;
    localparam t_kind KIND_PUBX  = 4'd5;

    localparam t_act ACT_NONE   = 4'd0;
    localparam t_act ACT_TIME   = 4'd1;
    localparam t_act ACT_LAT    = 4'd2;
    localparam t_act ACT_NS     = 4'd3;
    localparam t_act ACT_LON    = 4'd4;
    localparam t_act ACT_EW     = 4'd5;
    localparam t_act ACT_SPEED  = 4'd6;
    localparam t_act ACT_COURSE = 4'd7;
    localparam t_act ACT_DATE   = 4'd8;
    localparam t_act ACT_SATS   = 4'd9;
    localparam t_act ACT_HDOP   = 4'd10;
    localparam t_act ACT_ALT    = 4'd11;
    localparam t_act ACT_RMC_OK = 4'd12;
    localparam t_act ACT_GGA_OK = 4'd13;
    localparam t_act ACT_NAV_OK = 4'd14;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UD     = 8'h44;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UG     = 8'h47;
    localparam logic [7:0] CH_UR     = 8'h52;
    localparam logic [7:0] CH_US     = 8'h53;
    localparam logic [7:0] CH_UW     = 8'h57;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;

    localparam logic [31:0] BAD_ANGLE = 32'd999999999;
    localparam logic [31:0] BAD_ALL   = 32'hFFFF_FFFF;
    localparam logic [7:0]  BAD_SATS  = 8'hFF;

    // Term summary handed from the character accumulator to the sentence logic.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [31:0] whole;
        logic [6:0]  rem;
        logic [16:0] frac;
        logic [31:0] hund;
        logic [7:0]  count;
    } t_term_sum;

    typedef struct packed {
        logic        valid;
        logic        is_lon;
        logic [31:0] whole;
        logic [6:0]  rem;
        logic [16:0] frac;
    } t_deg_req;

    typedef struct packed {
        logic        valid;
        logic        is_lon;
        logic [31:0] mag;
    } t_deg_res;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] hex_value(logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_UA && c <= CH_UF) begin
            v = c - 8'd55;
        end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            v = c - 8'd87;
        end else begin
            v = c - CH_ZERO;
        end
        return v;
    endfunction

    // Weight of the k-th fractional minute digit, in units of 1e-5 minute.
    function automatic logic [13:0] frac_weight(logic [4:0] k);
        logic [13:0] w;
        unique case (k)
            5'd0:    w = 14'd10000;
            5'd1:    w = 14'd1000;
            5'd2:    w = 14'd100;
            5'd3:    w = 14'd10;
            5'd4:    w = 14'd1;
            default: w = 14'd0;
        endcase
        return w;
    endfunction

    // Which field a term fills, from sentence kind, vendor message and term number.
    function automatic t_act action_for(t_kind kind, logic [7:0] msg, logic [4:0] t);
        t_act a;
        a = ACT_NONE;
        unique case (kind)
            KIND_RMC: begin
                unique case (t)
                    5'd1:    a = ACT_TIME;
                    5'd2:    a = ACT_RMC_OK;
                    5'd3:    a = ACT_LAT;
                    5'd4:    a = ACT_NS;
                    5'd5:    a = ACT_LON;
                    5'd6:    a = ACT_EW;
                    5'd7:    a = ACT_SPEED;
                    5'd8:    a = ACT_COURSE;
                    5'd9:    a = ACT_DATE;
                    default: a = ACT_NONE;
                endcase
            end
            KIND_GGA: begin
                unique case (t)
                    5'd1:    a = ACT_TIME;
                    5'd2:    a = ACT_LAT;
                    5'd3:    a = ACT_NS;
                    5'd4:    a = ACT_LON;
                    5'd5:    a = ACT_EW;
                    5'd6:    a = ACT_GGA_OK;
                    5'd7:    a = ACT_SATS;
                    5'd8:    a = ACT_HDOP;
                    5'd9:    a = ACT_ALT;
                    default: a = ACT_NONE;
                endcase
            end
            KIND_GNS: begin
                unique case (t)
                    5'd1:    a = ACT_TIME;
                    5'd2:    a = ACT_LAT;
                    5'd3:    a = ACT_NS;
                    5'd4:    a = ACT_LON;
                    5'd5:    a = ACT_EW;
                    5'd7:    a = ACT_SATS;
                    default: a = ACT_NONE;
                endcase
            end
            KIND_ZDA: begin
                a = (t == 5'd1) ? ACT_TIME : ACT_NONE;
            end
            KIND_PUBX: begin
                if (msg == 8'd4) begin
                    a = (t == 5'd2) ? ACT_TIME : ((t == 5'd3) ? ACT_DATE : ACT_NONE);
                end else if (msg == 8'd0) begin
                    unique case (t)
                        5'd2:    a = ACT_TIME;
                        5'd3:    a = ACT_LAT;
                        5'd4:    a = ACT_NS;
                        5'd5:    a = ACT_LON;
                        5'd6:    a = ACT_EW;
                        5'd7:    a = ACT_ALT;
                        5'd8:    a = ACT_NAV_OK;
                        5'd11:   a = ACT_SPEED;
                        5'd12:   a = ACT_COURSE;
                        5'd15:   a = ACT_HDOP;
                        5'd18:   a = ACT_SATS;
                        default: a = ACT_NONE;
                    endcase
                end
            end
            default: a = ACT_NONE;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/nsd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the NMEA sentence decoder.
// Depends on nothing; used by the decoder top level.
interface nsd_char_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_in;
    logic [31:0] now_ms;

    modport source(output valid, char_in, now_ms, input ready);
    modport sink(input valid, char_in, now_ms, output ready);
endinterface

interface nsd_fix_if;
    logic               valid;
    logic               ready;
    logic               sentence_valid;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic [31:0]        utc_time;
    logic [31:0]        utc_date;
    logic [31:0]        ground_speed;
    logic [31:0]        heading;
    logic signed [31:0] height;
    logic [31:0]        dilution;
    logic [7:0]         satellites;
    logic [31:0]        position_stamp_ms;
    logic [31:0]        time_stamp_ms;

    modport source(output valid, sentence_valid, latitude, longitude, utc_time, utc_date,
                   ground_speed, heading, height, dilution, satellites,
                   position_stamp_ms, time_stamp_ms, input ready);
    modport sink(input valid, sentence_valid, latitude, longitude, utc_time, utc_date,
                 ground_speed, heading, height, dilution, satellites,
                 position_stamp_ms, time_stamp_ms, output ready);
endinterface

// File: rtl/nmea_sentence_decoder_core.sv
`timescale 1ns / 1ps
// Top level of the NMEA 0183 sentence decoder: sentence control, pending and committed fixes.
// Depends on nsd_pkg, nsd_if, nsd_term_acc and nsd_deg_conv.

// The decoder takes one received character and a millisecond time stamp per
// word on i_char and returns one word per character on o_fix, carrying a
// sentence-valid flag and the last committed fix. It takes a new character
// every clock cycle while the output register is free; the result appears in
// the next cycle and waits in the output register, so a character is accepted
// whenever that register is empty or is being read in the same cycle.
// Numbers are parsed as the characters arrive, so at a term separator the
// time, speed, course, height, dilution, date and satellite count are ready
// at once. Latitude and longitude are converted to millionths of a degree
// by short combinational logic at the separator and written to the pending
// value in the same cycle, so a checksum that follows right behind a
// position term already sees it. Checksummed sentences of kind RMC, GGA,
// ZDA and the PUBX 00 and 04 messages update the committed values; GNS
// fields are parsed, not committed; there is no clearing pass after reset.
module nmea_sentence_decoder_core #(
    parameter int TERM_LEN = 15
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    nsd_char_if.sink   i_char,
    nsd_fix_if.source  o_fix
);

    logic                 accept;
    logic [7:0]           c;
    logic                 is_term;
    logic                 is_dollar;
    nsd_pkg::t_term_sum   sum;
    nsd_pkg::t_deg_req    deg_req;
    nsd_pkg::t_deg_res    deg_res;

    logic [4:0]           r_idx;
    logic [7:0]           r_par;
    logic                 r_inck;
    nsd_pkg::t_kind       r_kind;
    logic [7:0]           r_msg;
    logic                 r_fix;

    // Pending values, filled term by term.
    logic [31:0] r_p_time, r_p_date, r_p_lat, r_p_lon, r_p_speed, r_p_course;
    logic [31:0] r_p_alt, r_p_hdop, r_p_tstamp, r_p_pstamp;
    logic [7:0]  r_p_sats;
    logic        r_p_lat_neg, r_p_lon_neg;

    // Committed values.
    logic [31:0] r_c_time, r_c_date, r_c_lat, r_c_lon, r_c_speed, r_c_course;
    logic [31:0] r_c_alt, r_c_hdop, r_c_tstamp, r_c_pstamp;
    logic [7:0]  r_c_sats;
    logic [31:0] n_c_time, n_c_date, n_c_lat, n_c_lon, n_c_speed, n_c_course;
    logic [31:0] n_c_alt, n_c_hdop, n_c_tstamp, n_c_pstamp;
    logic [7:0]  n_c_sats;

    logic        r_o_valid;

    logic        fin_ck, fin_kind, fin_msg, fin_act;
    nsd_pkg::t_act act;
    logic [7:0]  par_eff;
    logic [7:0]  hi_hex, lo_hex, ck_sum;
    logic        ck_ok, valid_now;
    logic        k_rmc, k_gga, k_zda, k_pubx0, k_pubx4;

    assign i_char.ready = !r_o_valid || o_fix.ready;
    assign accept    = i_char.valid && i_char.ready;
    assign c         = i_char.char_in;
    assign is_term   = (c == nsd_pkg::CH_COMMA) || (c == nsd_pkg::CH_CR) ||
                       (c == nsd_pkg::CH_LF) || (c == nsd_pkg::CH_STAR);
    assign is_dollar = (c == nsd_pkg::CH_DOLLAR);

    nsd_term_acc #(
        .TERM_LEN(TERM_LEN)
    ) u_term_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept && !is_term && !is_dollar),
        .i_clear (accept && (is_term || is_dollar)),
        .i_char  (c),
        .o_sum   (sum)
    );

    // Every term closes through the same decode: the checksum term, the
    // sentence name, the PUBX message number, or a data field.
    assign fin_ck   = accept && is_term && r_inck;
    assign fin_kind = accept && is_term && !r_inck && (r_idx == 5'd0);
    assign fin_msg  = accept && is_term && !r_inck && (r_idx == 5'd1) &&
                      (r_kind == nsd_pkg::KIND_PUBX);
    assign fin_act  = accept && is_term && !r_inck && (r_idx != 5'd0) && !fin_msg &&
                      (r_kind != nsd_pkg::KIND_OTHER) && (sum.c0 != nsd_pkg::CH_NUL);
    assign act      = fin_act ? nsd_pkg::action_for(r_kind, r_msg, r_idx) : nsd_pkg::ACT_NONE;

    assign deg_req.valid  = (act == nsd_pkg::ACT_LAT) || (act == nsd_pkg::ACT_LON);
    assign deg_req.is_lon = (act == nsd_pkg::ACT_LON);
    assign deg_req.whole  = sum.whole;
    assign deg_req.rem    = sum.rem;
    assign deg_req.frac   = sum.frac;

    nsd_deg_conv u_deg_conv (
        .i_req   (deg_req),
        .o_res   (deg_res)
    );

    // The comma is part of the checksummed text, so the comparison sees it
    // when the checksum term itself ends on a comma.
    assign par_eff = (c == nsd_pkg::CH_COMMA) ? (r_par ^ c) : r_par;
    assign hi_hex  = nsd_pkg::hex_value(sum.c0);
    assign lo_hex  = nsd_pkg::hex_value(sum.c1);
    assign ck_sum  = {hi_hex[3:0], 4'd0} + lo_hex;
    assign ck_ok   = fin_ck && (ck_sum == par_eff);
    assign valid_now = ck_ok && r_fix;

    assign k_rmc   = (r_kind == nsd_pkg::KIND_RMC);
    assign k_gga   = (r_kind == nsd_pkg::KIND_GGA);
    assign k_zda   = (r_kind == nsd_pkg::KIND_ZDA);
    assign k_pubx0 = (r_kind == nsd_pkg::KIND_PUBX) && (r_msg == 8'd0);
    assign k_pubx4 = (r_kind == nsd_pkg::KIND_PUBX) && (r_msg == 8'd4);

    // Commit rules: time goes through on RMC, PUBX 04 and ZDA, date on RMC and
    // PUBX 04, even without a fix; all else needs the fix flag of this sentence.
    always_comb begin
        n_c_time   = r_c_time;
        n_c_date   = r_c_date;
        n_c_lat    = r_c_lat;
        n_c_lon    = r_c_lon;
        n_c_speed  = r_c_speed;
        n_c_course = r_c_course;
        n_c_alt    = r_c_alt;
        n_c_hdop   = r_c_hdop;
        n_c_sats   = r_c_sats;
        n_c_tstamp = r_c_tstamp;
        n_c_pstamp = r_c_pstamp;
        if (ck_ok && (k_rmc || k_pubx4 || k_zda)) begin
            n_c_time   = r_p_time;
            n_c_tstamp = r_p_tstamp;
        end
        if (ck_ok && (k_rmc || k_pubx4)) begin
            n_c_date = r_p_date;
        end
        if (valid_now) begin
            n_c_tstamp = r_p_tstamp;
            n_c_pstamp = r_p_pstamp;
            if (k_rmc || k_gga || k_pubx0) begin
                n_c_time = r_p_time;
                n_c_lat  = r_p_lat_neg ? (32'd0 - r_p_lat) : r_p_lat;
                n_c_lon  = r_p_lon_neg ? (32'd0 - r_p_lon) : r_p_lon;
            end
            if (k_rmc) begin
                n_c_date = r_p_date;
            end
            if (k_rmc || k_pubx0) begin
                n_c_speed  = r_p_speed;
                n_c_course = r_p_course;
            end
            if (k_gga || k_pubx0) begin
                n_c_alt  = r_p_alt;
                n_c_sats = r_p_sats;
                n_c_hdop = r_p_hdop;
            end
        end
    end

    // Sentence-level control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_par  <= '0;
            r_inck <= 1'b0;
            r_kind <= nsd_pkg::KIND_OTHER;
            r_msg  <= '0;
            r_fix  <= 1'b0;
        end else if (accept) begin
            if (is_term) begin
                r_par  <= par_eff;
                r_idx  <= (r_idx == 5'd31) ? r_idx : (r_idx + 5'd1);
                r_inck <= (c == nsd_pkg::CH_STAR);
                if (fin_kind) begin
                    r_kind <= sum.kind;
                end
                if (fin_msg) begin
                    r_msg <= sum.whole[7:0];
                end
                unique case (act)
                    nsd_pkg::ACT_RMC_OK: r_fix <= (sum.c0 == nsd_pkg::CH_UA);
                    nsd_pkg::ACT_GGA_OK: r_fix <= (sum.c0 > nsd_pkg::CH_ZERO);
                    nsd_pkg::ACT_NAV_OK: r_fix <= (sum.c0 == nsd_pkg::CH_UG) ||
                                                  ((sum.c0 == nsd_pkg::CH_UD) &&
                                                   (sum.c1 != nsd_pkg::CH_UR));
                    default: ;
                endcase
            end else if (is_dollar) begin
                r_idx  <= '0;
                r_par  <= '0;
                r_inck <= 1'b0;
                r_kind <= nsd_pkg::KIND_OTHER;
                r_fix  <= 1'b0;
            end else if (!r_inck) begin
                r_par <= r_par ^ c;
            end
        end
    end

    // Pending values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_time    <= nsd_pkg::BAD_ALL;
            r_p_date    <= nsd_pkg::BAD_ALL;
            r_p_lat     <= nsd_pkg::BAD_ANGLE;
            r_p_lon     <= nsd_pkg::BAD_ANGLE;
            r_p_lat_neg <= 1'b0;
            r_p_lon_neg <= 1'b0;
            r_p_speed   <= nsd_pkg::BAD_ANGLE;
            r_p_course  <= nsd_pkg::BAD_ANGLE;
            r_p_alt     <= nsd_pkg::BAD_ANGLE;
            r_p_hdop    <= nsd_pkg::BAD_ALL;
            r_p_sats    <= nsd_pkg::BAD_SATS;
            r_p_tstamp  <= nsd_pkg::BAD_ALL;
            r_p_pstamp  <= nsd_pkg::BAD_ALL;
        end else begin
            if (deg_res.valid) begin
                if (deg_res.is_lon) begin
                    r_p_lon <= deg_res.mag;
                end else begin
                    r_p_lat <= deg_res.mag;
                end
            end
            unique case (act)
                nsd_pkg::ACT_TIME: begin
                    r_p_time   <= sum.hund;
                    r_p_tstamp <= i_char.now_ms;
                end
                nsd_pkg::ACT_LAT: begin
                    r_p_lat_neg <= 1'b0;
                    r_p_pstamp  <= i_char.now_ms;
                end
                nsd_pkg::ACT_NS: begin
                    if (sum.c0 == nsd_pkg::CH_US) begin
                        r_p_lat_neg <= !r_p_lat_neg;
                    end
                end
                nsd_pkg::ACT_LON:    r_p_lon_neg <= 1'b0;
                nsd_pkg::ACT_EW: begin
                    if (sum.c0 == nsd_pkg::CH_UW) begin
                        r_p_lon_neg <= !r_p_lon_neg;
                    end
                end
                nsd_pkg::ACT_SPEED:  r_p_speed  <= sum.hund;
                nsd_pkg::ACT_COURSE: r_p_course <= sum.hund;
                nsd_pkg::ACT_DATE:   r_p_date   <= sum.whole;
                nsd_pkg::ACT_SATS:   r_p_sats   <= sum.count;
                nsd_pkg::ACT_HDOP:   r_p_hdop   <= sum.hund;
                nsd_pkg::ACT_ALT:    r_p_alt    <= sum.hund;
                default: ;
            endcase
        end
    end

    // Committed values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_time   <= nsd_pkg::BAD_ALL;
            r_c_date   <= nsd_pkg::BAD_ALL;
            r_c_lat    <= nsd_pkg::BAD_ANGLE;
            r_c_lon    <= nsd_pkg::BAD_ANGLE;
            r_c_speed  <= nsd_pkg::BAD_ANGLE;
            r_c_course <= nsd_pkg::BAD_ANGLE;
            r_c_alt    <= nsd_pkg::BAD_ANGLE;
            r_c_hdop   <= nsd_pkg::BAD_ALL;
            r_c_sats   <= nsd_pkg::BAD_SATS;
            r_c_tstamp <= nsd_pkg::BAD_ALL;
            r_c_pstamp <= nsd_pkg::BAD_ALL;
        end else if (accept) begin
            r_c_time   <= n_c_time;
            r_c_date   <= n_c_date;
            r_c_lat    <= n_c_lat;
            r_c_lon    <= n_c_lon;
            r_c_speed  <= n_c_speed;
            r_c_course <= n_c_course;
            r_c_alt    <= n_c_alt;
            r_c_hdop   <= n_c_hdop;
            r_c_sats   <= n_c_sats;
            r_c_tstamp <= n_c_tstamp;
            r_c_pstamp <= n_c_pstamp;
        end
    end

    // Output register: one result word per accepted character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (accept) begin
            r_o_valid <= 1'b1;
        end else if (o_fix.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_fix.sentence_valid    <= valid_now;
            o_fix.latitude          <= n_c_lat;
            o_fix.longitude         <= n_c_lon;
            o_fix.utc_time          <= n_c_time;
            o_fix.utc_date          <= n_c_date;
            o_fix.ground_speed      <= n_c_speed;
            o_fix.heading           <= n_c_course;
            o_fix.height            <= n_c_alt;
            o_fix.dilution          <= n_c_hdop;
            o_fix.satellites        <= n_c_sats;
            o_fix.position_stamp_ms <= n_c_pstamp;
            o_fix.time_stamp_ms     <= n_c_tstamp;
        end
    end

    assign o_fix.valid = r_o_valid;

endmodule

// File: rtl/nsd_term_acc.sv
`timescale 1ns / 1ps
// Per-character term accumulator: keeps the head of the term and running number parsers.
// Depends on nsd_pkg.
module nsd_term_acc #(
    parameter int TERM_LEN = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_clear,
    input  logic [7:0]           i_char,
    output nsd_pkg::t_term_sum   o_sum
);

    localparam int LW = $clog2(TERM_LEN);

    localparam logic [1:0] M_INT  = 2'd0;
    localparam logic [1:0] M_FRAC = 2'd1;
    localparam logic [1:0] M_DONE = 2'd2;

    localparam logic [1:0] H_INT  = 2'd0;
    localparam logic [1:0] H_DOT  = 2'd1;
    localparam logic [1:0] H_F1   = 2'd2;
    localparam logic [1:0] H_DONE = 2'd3;

    localparam logic [1:0] S_BLANK = 2'd0;
    localparam logic [1:0] S_DIG   = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [LW-1:0] r_len;
    logic [7:0]    r_txt [0:5];
    logic [31:0]   r_w;
    logic [6:0]    r_rem;
    logic [1:0]    r_mst;
    logic [LW-1:0] r_fk;
    logic [16:0]   r_fsum;
    logic          r_hneg;
    logic [31:0]   r_hi;
    logic [1:0]    r_hst;
    logic [3:0]    r_f1;
    logic [3:0]    r_f2;
    logic          r_sneg;
    logic [7:0]    r_sv;
    logic [1:0]    r_sst;

    logic          take;
    logic          dig;
    logic [3:0]    d;
    logic [35:0]   w_full;
    logic [10:0]   rem_sum;
    logic [21:0]   rem_prod;
    logic [3:0]    rem_q;
    logic [6:0]    rem_next;
    logic [31:0]   hi_next;
    logic [16:0]   fsum_next;
    logic          blank;
    logic [7:0]    ch [0:5];
    logic [31:0]   hund_abs;
    logic [7:0]    sv_next;

    assign take = i_step && !i_clear && (r_len < LW'(TERM_LEN - 1));
    assign dig  = nsd_pkg::is_digit(i_char);
    assign d    = 4'(i_char - nsd_pkg::CH_ZERO);

    // Whole-degree digits wrap at 32 bits; the value mod 100 follows the wrap
    // because 2^32 mod 100 is 96, so each carry-out adds 4 modulo 100.
    assign w_full   = ({4'd0, r_w} << 3) + ({4'd0, r_w} << 1) + 36'(d);
    assign rem_sum  = 11'(r_rem) * 11'd10 + 11'(d) + 11'(w_full[35:32]) * 11'd4;
    assign rem_prod = 22'(rem_sum) * 22'd1311;
    assign rem_q    = rem_prod[20:17];
    assign rem_next = 7'(rem_sum - 11'(rem_q) * 11'd100);
    assign hi_next  = (r_hi << 3) + (r_hi << 1) + 32'(d);
    assign sv_next  = 8'((r_sv << 3) + (r_sv << 1) + 8'(d));
    assign fsum_next = r_fsum + 17'(nsd_pkg::frac_weight(5'(r_fk)) * 14'(d));
    assign blank = (i_char == nsd_pkg::CH_SPACE) || (i_char == nsd_pkg::CH_TAB) ||
                   (i_char == nsd_pkg::CH_VT) || (i_char == nsd_pkg::CH_FF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_len  <= '0;
            r_w    <= '0;
            r_rem  <= '0;
            r_mst  <= M_INT;
            r_fk   <= '0;
            r_fsum <= '0;
            r_hneg <= 1'b0;
            r_hi   <= '0;
            r_hst  <= H_INT;
            r_f1   <= '0;
            r_f2   <= '0;
            r_sneg <= 1'b0;
            r_sv   <= '0;
            r_sst  <= S_BLANK;
        end else if (take) begin
            r_len <= r_len + LW'(1);

            unique case (r_mst)
                M_INT: begin
                    if (dig) begin
                        r_w   <= w_full[31:0];
                        r_rem <= rem_next;
                    end else if (i_char == nsd_pkg::CH_DOT) begin
                        r_mst <= M_FRAC;
                    end else begin
                        r_mst <= M_DONE;
                    end
                end
                M_FRAC: begin
                    if (dig) begin
                        r_fsum <= fsum_next;
                        r_fk   <= r_fk + LW'(1);
                    end else begin
                        r_mst <= M_DONE;
                    end
                end
                default: ;
            endcase

            unique case (r_hst)
                H_INT: begin
                    if (r_len == '0 && i_char == nsd_pkg::CH_MINUS) begin
                        r_hneg <= 1'b1;
                    end else if (dig) begin
                        r_hi <= hi_next;
                    end else if (i_char == nsd_pkg::CH_DOT) begin
                        r_hst <= H_DOT;
                    end else begin
                        r_hst <= H_DONE;
                    end
                end
                H_DOT: begin
                    if (dig) begin
                        r_f1  <= d;
                        r_hst <= H_F1;
                    end else begin
                        r_hst <= H_DONE;
                    end
                end
                H_F1: begin
                    if (dig) begin
                        r_f2 <= d;
                    end
                    r_hst <= H_DONE;
                end
                default: ;
            endcase

            unique case (r_sst)
                S_BLANK: begin
                    if (blank) begin
                        r_sst <= S_BLANK;
                    end else if (i_char == nsd_pkg::CH_MINUS || i_char == nsd_pkg::CH_PLUS) begin
                        r_sneg <= (i_char == nsd_pkg::CH_MINUS);
                        r_sst  <= S_DIG;
                    end else if (dig) begin
                        r_sv  <= 8'(d);
                        r_sst <= S_DIG;
                    end else begin
                        r_sst <= S_DONE;
                    end
                end
                S_DIG: begin
                    if (dig) begin
                        r_sv <= sv_next;
                    end else begin
                        r_sst <= S_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    // Head of the term; unwritten places are never read past the length.
    always_ff @(posedge i_clk) begin
        if (take && r_len < LW'(6)) begin
            r_txt[3'(r_len)] <= i_char;
        end
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            ch[i] = (r_len > LW'(i)) ? r_txt[i] : nsd_pkg::CH_NUL;
        end
    end

    assign hund_abs = (r_hi << 6) + (r_hi << 5) + (r_hi << 2) +
                      32'(r_f1) * 32'd10 + 32'(r_f2);

    always_comb begin
        logic tail5;
        logic tail4;
        tail5 = (ch[5] == nsd_pkg::CH_NUL);
        tail4 = (ch[4] == nsd_pkg::CH_NUL);
        o_sum.kind = nsd_pkg::KIND_OTHER;
        if (ch[0] == "G" && ch[2] == "R" && ch[3] == "M" && ch[4] == "C" && tail5 &&
            (ch[1] == "P" || ch[1] == "N")) begin
            o_sum.kind = nsd_pkg::KIND_RMC;
        end else if (ch[0] == "G" && ch[1] == "P" && ch[2] == "G" && ch[3] == "G" &&
                     ch[4] == "A" && tail5) begin
            o_sum.kind = nsd_pkg::KIND_GGA;
        end else if (ch[0] == "G" && ch[1] == "N" && ch[2] == "G" && ch[3] == "N" &&
                     ch[4] == "S" && tail5) begin
            o_sum.kind = nsd_pkg::KIND_GNS;
        end else if (ch[0] == "G" && ch[1] == "P" && ch[2] == "Z" && ch[3] == "D" &&
                     ch[4] == "A" && tail5) begin
            o_sum.kind = nsd_pkg::KIND_ZDA;
        end else if (ch[0] == "P" && ch[1] == "U" && ch[2] == "B" && ch[3] == "X" && tail4) begin
            o_sum.kind = nsd_pkg::KIND_PUBX;
        end
        o_sum.c0    = ch[0];
        o_sum.c1    = ch[1];
        o_sum.whole = r_w;
        o_sum.rem   = r_rem;
        o_sum.frac  = r_fsum;
        o_sum.hund  = r_hneg ? (32'd0 - hund_abs) : hund_abs;
        o_sum.count = r_sneg ? (8'd0 - r_sv) : r_sv;
    end

endmodule

// File: rtl/nsd_deg_conv.sv
`timescale 1ns / 1ps
// Combinational conversion of ddmm.mmmm digits into millionths of a degree.
// Depends on nsd_pkg.
module nsd_deg_conv (
    input  nsd_pkg::t_deg_req  i_req,
    output nsd_pkg::t_deg_res  o_res
);

    // Division by 6 of values below 2^25 by reciprocal multiply.
    localparam logic [47:0] RECIP6  = 48'd11184811;

    logic [31:0] whole_part;
    logic [23:0] minutes;
    logic [47:0] div6;

    // The whole number minus its remainder mod 100 is an exact multiple of
    // 100, so whole degrees times one million is that difference times 10000,
    // which also holds modulo 2^32.
    assign whole_part = (i_req.whole - 32'(i_req.rem)) * 32'd10000;
    assign minutes    = 24'(i_req.rem) * 24'd100000 + 24'(i_req.frac) + 24'd3;
    assign div6       = 48'(minutes) * RECIP6;

    assign o_res.valid  = i_req.valid;
    assign o_res.is_lon = i_req.is_lon;
    assign o_res.mag    = whole_part + 32'(div6[46:26]);

endmodule

// File: rtl/nsd_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the NMEA sentence decoder and its bind to the top level.
// Depends on nsd_pkg and nmea_sentence_decoder_core.
module nsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [7:0]  i_in_char,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_sentence_valid,
    input logic [31:0] i_out_latitude
);

    logic in_acc;
    logic in_sep;

    assign in_acc = i_in_valid && i_in_ready;
    assign in_sep = (i_in_char == nsd_pkg::CH_COMMA) || (i_in_char == nsd_pkg::CH_STAR) ||
                    (i_in_char == nsd_pkg::CH_CR) || (i_in_char == nsd_pkg::CH_LF);

    // Each accepted character produces a result word in the next cycle.
    a_word_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> i_out_valid)
        else $error("accepted character produced no result word");

    // Only a term separator can complete a sentence.
    a_valid_on_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !in_sep) |=> !i_out_sentence_valid)
        else $error("sentence valid without a term separator");

    // An empty output register never blocks the input.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output register empty");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_latitude)))
        else $error("stalled result word changed");

endmodule

bind nmea_sentence_decoder_core nsd_checker u_nsd_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_char.valid),
    .i_in_ready           (i_char.ready),
    .i_in_char            (i_char.char_in),
    .i_out_valid          (o_fix.valid),
    .i_out_ready          (o_fix.ready),
    .i_out_sentence_valid (o_fix.sentence_valid),
    .i_out_latitude       (o_fix.latitude)
);

// File: test/nsd_fix_checker.sv
`timescale 1ns / 1ps
// Checker of the NMEA sentence decoder: watches both channels, predicts every fix word.
// Depends on nsd_pkg and nsd_if.
module nsd_fix_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    nsd_char_if  i_char,
    nsd_fix_if   i_fix,
    output int   o_errors,
    output int   o_waiting
);
    import nsd_pkg::*;

    localparam int TLEN = 15;

    typedef enum int {
        F_TIME, F_DATE, F_LAT, F_LON, F_SPEED, F_HEADING, F_ALT, F_HDOP, F_SATS,
        F_TSTAMP, F_PSTAMP, F_COUNT
    } t_field;

    typedef struct {
        logic        good;
        logic [31:0] lat, lon, utc, date, speed, course, alt, hdop, pstamp, tstamp;
        logic [7:0]  sats;
    } t_fix;

    logic [7:0]  text [TLEN];
    int          tlen, tidx;
    logic [7:0]  parity;
    logic        in_sum, fix_ok;
    t_kind       kind;
    logic [7:0]  msg_no;
    logic [31:0] pend [F_COUNT];
    logic [31:0] comm [F_COUNT];
    t_fix        expected_fixes [$];
    int          errors;

    assign o_errors  = errors;
    assign o_waiting = expected_fixes.size();

    function automatic void clear_state();
        for (int i = 0; i < TLEN; i++) text[i] = CH_NUL;
        tlen = 0; tidx = 0; parity = 0; in_sum = 0; fix_ok = 0;
        kind = KIND_OTHER; msg_no = 0;
        for (int i = 0; i < F_COUNT; i++) begin
            pend[i] = (i == F_SATS) ? 32'hFF :
                      (i >= F_LAT && i <= F_ALT) ? BAD_ANGLE : BAD_ALL;
            comm[i] = pend[i];
        end
    endfunction

    function automatic logic [7:0] at(int i);
        return (i < tlen && i < TLEN) ? text[i] : CH_NUL;
    endfunction

    function automatic logic dig(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [31:0] number_at(int p, output int q);
        logic [31:0] v;
        v = 0;
        while (p < TLEN && dig(at(p))) begin
            v = 32'd10 * v + 32'(at(p) - CH_ZERO);
            p++;
        end
        q = p;
        return v;
    endfunction

    function automatic logic [7:0] nibble(logic [7:0] c);
        if (c >= CH_UA && c <= CH_UF) return c - 8'd55;
        if (c >= CH_LA && c <= CH_LF_HEX) return c - 8'd87;
        return c - CH_ZERO;
    endfunction

    function automatic logic name_is(string n);
        for (int i = 0; i < n.len(); i++)
            if (at(i) != n[i]) return 0;
        return at(n.len()) == CH_NUL;
    endfunction

    // Signed decimal with at most two fractional digits, in hundredths.
    function automatic logic [31:0] cents();
        int q;
        logic neg;
        logic [31:0] r;
        neg = at(0) == CH_MINUS;
        r = 32'd100 * number_at(neg ? 1 : 0, q);
        if (at(q) == CH_DOT && dig(at(q + 1))) begin
            r += 32'd10 * 32'(at(q + 1) - CH_ZERO);
            if (dig(at(q + 2))) r += 32'(at(q + 2) - CH_ZERO);
        end
        return neg ? -r : r;
    endfunction

    // dddmm.mmmm to millionths of a degree.
    function automatic logic [31:0] degrees();
        int q;
        logic [31:0] whole, frac, wt;
        whole = number_at(0, q);
        frac = (whole % 32'd100) * 32'd100000;
        wt = 32'd10000;
        if (at(q) == CH_DOT) begin
            q++;
            while (q < TLEN && dig(at(q))) begin
                frac += wt * 32'(at(q) - CH_ZERO);
                wt = wt / 32'd10;
                q++;
            end
        end
        return (whole / 32'd100) * 32'd1000000 + (frac + 32'd3) / 32'd6;
    endfunction

    function automatic logic [31:0] sat_count();
        int p, q;
        logic neg;
        logic [7:0] c;
        logic [31:0] v;
        p = 0; neg = 0; c = at(0);
        while (p < TLEN && (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)) begin
            p++;
            c = at(p);
        end
        if (c == CH_MINUS || c == CH_PLUS) begin
            neg = c == CH_MINUS;
            p++;
        end
        v = number_at(p, q);
        if (neg) v = -v;
        return v & 32'hFF;
    endfunction

    function automatic t_act field_of();
        case (kind)
            KIND_RMC: case (tidx)
                1: return ACT_TIME;   2: return ACT_RMC_OK; 3: return ACT_LAT;
                4: return ACT_NS;     5: return ACT_LON;    6: return ACT_EW;
                7: return ACT_SPEED;  8: return ACT_COURSE; 9: return ACT_DATE;
                default: return ACT_NONE;
            endcase
            KIND_GGA: case (tidx)
                1: return ACT_TIME;   2: return ACT_LAT;    3: return ACT_NS;
                4: return ACT_LON;    5: return ACT_EW;     6: return ACT_GGA_OK;
                7: return ACT_SATS;   8: return ACT_HDOP;   9: return ACT_ALT;
                default: return ACT_NONE;
            endcase
            KIND_GNS: case (tidx)
                1: return ACT_TIME;   2: return ACT_LAT;    3: return ACT_NS;
                4: return ACT_LON;    5: return ACT_EW;     7: return ACT_SATS;
                default: return ACT_NONE;
            endcase
            KIND_ZDA: return tidx == 1 ? ACT_TIME : ACT_NONE;
            KIND_PUBX: begin
                if (msg_no == 8'd4)
                    return tidx == 2 ? ACT_TIME : (tidx == 3 ? ACT_DATE : ACT_NONE);
                if (msg_no == 8'd0) case (tidx)
                    2: return ACT_TIME;   3: return ACT_LAT;    4: return ACT_NS;
                    5: return ACT_LON;    6: return ACT_EW;     7: return ACT_ALT;
                    8: return ACT_NAV_OK; 11: return ACT_SPEED; 12: return ACT_COURSE;
                    15: return ACT_HDOP;  18: return ACT_SATS;
                    default: return ACT_NONE;
                endcase
                return ACT_NONE;
            end
            default: return ACT_NONE;
        endcase
    endfunction

    function automatic void take(t_field f);
        comm[f] = pend[f];
    endfunction

    function automatic logic check_sum();
        logic [7:0] s;
        logic [7:0] hi;
        logic ubx0;
        hi = nibble(at(0));
        s = {hi[3:0], 4'h0} + nibble(at(1));
        ubx0 = kind == KIND_PUBX && msg_no == 8'd0;
        if (s != parity) return 0;
        if (kind == KIND_RMC || (kind == KIND_PUBX && msg_no == 8'd4)) begin
            take(F_TIME); take(F_DATE); take(F_TSTAMP);
        end
        if (kind == KIND_ZDA) begin
            take(F_TIME); take(F_TSTAMP);
        end
        if (!fix_ok) return 0;
        take(F_TSTAMP); take(F_PSTAMP);
        if (kind == KIND_RMC || kind == KIND_GGA || ubx0) begin
            take(F_TIME); take(F_LAT); take(F_LON);
        end
        if (kind == KIND_RMC) take(F_DATE);
        if (kind == KIND_RMC || ubx0) begin
            take(F_SPEED); take(F_HEADING);
        end
        if (kind == KIND_GGA || ubx0) begin
            take(F_ALT); take(F_SATS); take(F_HDOP);
        end
        return 1;
    endfunction

    function automatic logic close_term(logic [31:0] now);
        logic [7:0] c0;
        int q;
        c0 = at(0);
        if (in_sum) return check_sum();
        if (tidx == 0) begin
            if (name_is("GPRMC") || name_is("GNRMC")) kind = KIND_RMC;
            else if (name_is("GPGGA")) kind = KIND_GGA;
            else if (name_is("GNGNS")) kind = KIND_GNS;
            else if (name_is("GPZDA")) kind = KIND_ZDA;
            else if (name_is("PUBX")) kind = KIND_PUBX;
            else kind = KIND_OTHER;
            return 0;
        end
        if (kind == KIND_PUBX && tidx == 1) begin
            msg_no = 8'(number_at(0, q));
            return 0;
        end
        if (kind == KIND_OTHER || c0 == CH_NUL) return 0;
        case (field_of())
            ACT_TIME: begin
                pend[F_TIME] = cents();
                pend[F_TSTAMP] = now;
            end
            ACT_LAT: begin
                pend[F_LAT] = degrees();
                pend[F_PSTAMP] = now;
            end
            ACT_NS:     if (c0 == CH_US) pend[F_LAT] = -pend[F_LAT];
            ACT_LON:    pend[F_LON] = degrees();
            ACT_EW:     if (c0 == CH_UW) pend[F_LON] = -pend[F_LON];
            ACT_SPEED:  pend[F_SPEED] = cents();
            ACT_COURSE: pend[F_HEADING] = cents();
            ACT_DATE:   pend[F_DATE] = number_at(0, q);
            ACT_SATS:   pend[F_SATS] = sat_count();
            ACT_HDOP:   pend[F_HDOP] = cents();
            ACT_ALT:    pend[F_ALT] = cents();
            ACT_RMC_OK: fix_ok = c0 == CH_UA;
            ACT_GGA_OK: fix_ok = c0 > CH_ZERO;
            ACT_NAV_OK: fix_ok = c0 == CH_UG || (c0 == CH_UD && at(1) != CH_UR);
            default: ;
        endcase
        return 0;
    endfunction

    function automatic t_fix decode_char(logic [7:0] c, logic [31:0] now);
        t_fix r;
        r.good = 0;
        if (c == CH_COMMA || c == CH_CR || c == CH_LF || c == CH_STAR) begin
            if (c == CH_COMMA) parity ^= c;
            if (tlen < TLEN) r.good = close_term(now);
            if (tidx < 31) tidx++;
            tlen = 0;
            in_sum = c == CH_STAR;
        end else if (c == CH_DOLLAR) begin
            tidx = 0; tlen = 0; parity = 0; kind = KIND_OTHER; in_sum = 0; fix_ok = 0;
        end else begin
            if (tlen < TLEN - 1) begin
                text[tlen] = c;
                tlen++;
            end
            if (!in_sum) parity ^= c;
        end
        r.lat = comm[F_LAT];       r.lon = comm[F_LON];
        r.utc = comm[F_TIME];      r.date = comm[F_DATE];
        r.speed = comm[F_SPEED];   r.course = comm[F_HEADING];
        r.alt = comm[F_ALT];       r.hdop = comm[F_HDOP];
        r.sats = comm[F_SATS][7:0];
        r.pstamp = comm[F_PSTAMP]; r.tstamp = comm[F_TSTAMP];
        return r;
    endfunction

    function automatic void compare(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    initial begin
        errors = 0;
        clear_state();
    end

    always @(posedge i_clk) begin
        t_fix w;
        if (!i_rst_n) begin
            clear_state();
            expected_fixes.delete();
        end else begin
            if (i_fix.valid && i_fix.ready) begin
                if (expected_fixes.size() == 0) begin
                    $display("%0t: fix word with nothing expected", $time);
                    errors++;
                end else begin
                    w = expected_fixes.pop_front();
                    compare("sentence_valid", 32'(w.good), 32'(i_fix.sentence_valid));
                    compare("latitude", w.lat, i_fix.latitude);
                    compare("longitude", w.lon, i_fix.longitude);
                    compare("utc_time", w.utc, i_fix.utc_time);
                    compare("utc_date", w.date, i_fix.utc_date);
                    compare("ground_speed", w.speed, i_fix.ground_speed);
                    compare("heading", w.course, i_fix.heading);
                    compare("height", w.alt, i_fix.height);
                    compare("dilution", w.hdop, i_fix.dilution);
                    compare("satellites", 32'(w.sats), 32'(i_fix.satellites));
                    compare("position_stamp_ms", w.pstamp, i_fix.position_stamp_ms);
                    compare("time_stamp_ms", w.tstamp, i_fix.time_stamp_ms);
                end
            end
            if (i_char.valid && i_char.ready)
                expected_fixes.push_back(decode_char(i_char.char_in, i_char.now_ms));
        end
    end
endmodule

// File: test/nmea_sentence_decoder_core_tb.sv
`timescale 1ns / 1ps
// Testbench top of the NMEA sentence decoder: makes sentences, noise and the verdict.
// Depends on nsd_pkg, nsd_if, nmea_sentence_decoder_core and nsd_fix_checker.
module nmea_sentence_decoder_core_tb;
    import nsd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_CHARS = 1200;

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    int   errors;
    int   waiting;
    int   sent;
    logic calm;       // no idling on either side
    logic quiet_src;  // a stretch with no sender gaps
    logic drained;    // the drain pause has been done
    logic [31:0] clock_ms;
    int   stall_left;

    nsd_char_if chars ();
    nsd_fix_if  fixes ();

    nmea_sentence_decoder_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_char (chars.sink),
        .o_fix  (fixes.source)
    );

    nsd_fix_checker i_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (chars),
        .i_fix    (fixes),
        .o_errors (errors),
        .o_waiting(waiting)
    );

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        chars.valid = 0;
        chars.char_in = 0;
        chars.now_ms = 0;
        fixes.ready = 0;
        calm = 0;
        quiet_src = 0;
        drained = 0;
        cycles = 0;
        stall_left = 0;
        clock_ms = 32'hFFFF_FF00;
    end

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The receiver stalls in random bursts, except near the end.
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            fixes.ready <= !i_rst_n ? 1'b0 : 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            fixes.ready <= 1'b0;
        end else if ($urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 16);
            fixes.ready <= 1'b0;
        end else begin
            fixes.ready <= 1'b1;
        end
    end

    // One character word. The millisecond clock mostly creeps forward but
    // sometimes jumps anywhere, so every stamp bit toggles.
    task automatic send_char(logic [7:0] c, logic [31:0] now);
        if (!calm && !quiet_src && $urandom_range(0, 9) == 0) begin
            chars.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        chars.valid <= 1'b1;
        chars.char_in <= c;
        chars.now_ms <= now;
        do @(posedge i_clk); while (!chars.ready);
        sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[i]) begin
            clock_ms = ($urandom_range(0, 30) == 0) ? $urandom : clock_ms + $urandom_range(0, 40);
            send_char(s[i], clock_ms);
        end
    endtask

    // Digits with an optional fraction; ndig < 0 yields an empty field.
    function automatic string num(int ndig, int nfrac);
        string s;
        s = "";
        if (ndig < 0) return s;
        for (int i = 0; i < ndig; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        if (nfrac >= 0) begin
            s = {s, "."};
            for (int i = 0; i < nfrac; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        end
        return s;
    endfunction

    function automatic string rnum(int ndig);
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return "";
        if (pick == 1) return num(13, 4);   // longer than a term holds
        if (pick == 2) return {"-", num(ndig, 2)};
        return num($urandom_range(0, ndig), $urandom_range(0, 3) == 0 ? -1 : $urandom_range(0, 6));
    endfunction

    function automatic string pick_of(string a, string b, string c);
        int k;
        k = $urandom_range(0, 2);
        return k == 0 ? a : (k == 1 ? b : c);
    endfunction

    // Whole sentence around a body, with a correct checksum when good_sum is set.
    function automatic string wrap(string body, logic good_sum);
        logic [7:0] x;
        string h;
        x = 0;
        foreach (body[i]) x ^= body[i];
        if (!good_sum) x ^= 8'(1 << $urandom_range(0, 7));
        h = $urandom_range(0, 3) == 0 ? $sformatf("%02x", x) : $sformatf("%02X", x);
        return {$urandom_range(0, 19) == 0 ? "" : "$", body, "*", h,
                $urandom_range(0, 4) == 0 ? "," : "\r\n"};
    endfunction

    function automatic string random_body();
        string s;
        case ($urandom_range(0, 8))
            0, 1: s = {pick_of("GPRMC", "GNRMC", "GPRMC"), ",", rnum(6), ",",
                       pick_of("A", "V", "A"), ",", rnum(4), ",", pick_of("N", "S", ""),
                       ",", rnum(5), ",", pick_of("E", "W", "W"), ",", rnum(3), ",",
                       rnum(3), ",", rnum(6), ",,"};
            2, 3: s = {"GPGGA,", rnum(6), ",", rnum(4), ",", pick_of("N", "S", "S"), ",",
                       rnum(5), ",", pick_of("E", "W", ""), ",", pick_of("1", "0", "2"),
                       ",", pick_of(num(2, -1), " -3", "+12"), ",", rnum(2), ",",
                       rnum(4), ",M,,M,,"};
            4:    s = {"GNGNS,", rnum(6), ",", rnum(4), ",N,", rnum(5), ",W,AN,",
                       num(2, -1), ",1.0"};
            5:    s = {"GPZDA,", rnum(6), ",", num(2, -1), ",", num(2, -1), ",2024"};
            6:    s = {"PUBX,00,", rnum(6), ",", rnum(4), ",", pick_of("N", "S", "S"), ",",
                       rnum(5), ",", pick_of("E", "W", "W"), ",", rnum(4), ",",
                       pick_of("G3", "DR", pick_of("D2", "NF", "G2")), ",1.0,2.0,",
                       rnum(3), ",", rnum(3), ",0.0,,", rnum(2), ",1.1,1.2,",
                       pick_of(num(2, -1), "", " 7")};
            7:    s = {"PUBX,", pick_of("04", "4", "03"), ",", rnum(6), ",", num(6, -1),
                       ",", rnum(6)};
            default: begin
                s = pick_of("GPGSV", "GPRMCX", "PUBX0");
                repeat ($urandom_range(1, 36)) s = {s, ",", rnum(3)};
            end
        endcase
        return s;
    endfunction

    task automatic noise();
        repeat ($urandom_range(1, 6)) begin
            clock_ms = $urandom;
            send_char(8'($urandom_range(0, 255)), clock_ms);
        end
    endtask

    initial begin
        sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every sentence kind, south and west, fix and no fix,
        // long terms and the extremes of both fields.
        send_char(8'h00, 32'h0000_0000);
        send_char(8'hFF, 32'hFFFF_FFFF);
        send_text(wrap("GPRMC,235959.99,A,8959.99999,S,17959.99999,W,999.99,359.99,311299,,",
                       1'b1));
        send_text(wrap("GPGGA,000000.00,0000.0000,N,00000.0000,E,1, 08,0.9,-12.34,M,,M,,",
                       1'b1));
        send_text(wrap("PUBX,00,1.5,4807.038,N,01131.000,W,-5,DR,1,1,2.5,90.1,0,,0.7,1,1,+9",
                       1'b1));
        send_text(wrap("PUBX,00,1.5,4807.038,N,01131.000,E,5,G3,1,1,2.5,90.1,0,,0.7,1,1,-3",
                       1'b1));
        send_text(wrap("PUBX,04,123456.7,010203", 1'b1));
        send_text(wrap("GPZDA,101010.10,01,02,2003", 1'b1));
        send_text(wrap("GNGNS,111111,1234.5678,S,12345.6789,W,AN,11,1.0", 1'b1));
        send_text(wrap("GNRMC,1,V,1,N,1,E,1,1,1", 1'b0));
        send_text(wrap("GPRMCX,1,A", 1'b1));
        send_text(wrap("GPRMC,123456789012345678,A,4807.0381234567,N,,E,,,", 1'b1));
        send_text(wrap("GPGSV,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17,18,19,20,21,22,23,24,"
                       , 1'b1));

        // Random: mostly well-formed sentences, some broken ones and noise.
        while (sent < RANDOM_CHARS) begin
            quiet_src = $urandom_range(0, 4) == 0;
            if (!drained && sent > RANDOM_CHARS / 2) begin
                // Hold off until every outstanding fix word has drained.
                drained = 1;
                chars.valid <= 1'b0;
                @(posedge i_clk);
                while (waiting != 0) @(posedge i_clk);
            end
            if (sent > RANDOM_CHARS - 200) calm = 1;
            case ($urandom_range(0, 9))
                0:       noise();
                1:       send_text(wrap(random_body(), 1'b0));
                default: send_text(wrap(random_body(), 1'b1));
            endcase
        end
        chars.valid <= 1'b0;

        while (waiting != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: nmea_sentence_decoder_core.f
rtl/nsd_pkg.sv
rtl/nsd_if.sv
rtl/nsd_term_acc.sv
rtl/nsd_deg_conv.sv
rtl/nmea_sentence_decoder_core.sv
rtl/nsd_checker.sv
test/nsd_fix_checker.sv
test/nmea_sentence_decoder_core_tb.sv
